// ===== src/abkf_pkg.sv =====
// Package with types, constants and helpers for the angle/bias Kalman filter.
package abkf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned CfgW   = 31;
    localparam int unsigned DtW    = 16;
    localparam int unsigned FracW  = 16;
    localparam int unsigned DivCntW = 6;

    localparam logic [1:0] RegAngleNoise = 2'd0;
    localparam logic [1:0] RegBiasNoise  = 2'd1;
    localparam logic [1:0] RegMeasNoise  = 2'd2;

    localparam logic [CfgW-1:0] AngleNoiseRst = 31'd52429;
    localparam logic [CfgW-1:0] BiasNoiseRst  = 31'd655;
    localparam logic [CfgW-1:0] MeasNoiseRst  = 31'd32768;

    localparam logic signed [33:0] HalfTurn = 34'sd11796480;
    localparam logic signed [33:0] FullTurn = 34'sd23592960;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_ANG,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_AA,
        ST_AB,
        ST_BB,
        ST_INNOV,
        ST_S,
        ST_DIV0,
        ST_DIV1,
        ST_CA,
        ST_CB,
        ST_P00,
        ST_P01,
        ST_P10,
        ST_P11,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic [DataW-1:0] sat34(input logic signed [33:0] v);
        logic [DataW-1:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[DataW-1:0];
        end
        return r;
    endfunction

    // Round a 64-bit product to Q16.16 (half up) and saturate.
    function automatic logic [DataW-1:0] rnd_sat(input logic signed [63:0] p);
        logic signed [64:0] n;
        logic signed [48:0] q;
        logic [DataW-1:0] r;
        n = {p[63], p} + 65'sd32768;
        q = n[64:16];
        if (q > 49'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (q < -49'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = q[DataW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/abkf_div.sv =====
// Iterative signed divider for (num << 16) / den with truncation and saturation.
module abkf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  abkf_pkg::t_div_ctl         i_ctl,
    input  logic [31:0]                i_num,
    input  logic [31:0]                i_den,
    output logic                       o_done,
    output logic [31:0]                o_quot
);
    import abkf_pkg::*;

    logic [47:0]        r_rem;
    logic [47:0]        r_quo;
    logic [31:0]        r_den;
    logic               r_neg;
    logic               r_zero;
    logic [DivCntW-1:0] r_cnt;
    logic               r_run;
    logic               r_done;
    logic [47:0]        n_rem_sh;
    logic [48:0]        n_diff;
    logic [31:0]        num_abs;
    logic [31:0]        den_abs;
    logic signed [49:0] sq;

    assign num_abs = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign den_abs = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign n_rem_sh = {r_rem[46:0], r_quo[47]};
    assign n_diff = {1'b0, n_rem_sh} - {17'd0, r_den};

    // One quotient bit per cycle, 48 bits in all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= {num_abs, 16'd0};
                r_den  <= den_abs;
                r_neg  <= i_num[31] ^ i_den[31];
                r_zero <= (i_den == 32'd0);
            end else if (r_run) begin
                if (!n_diff[48]) begin
                    r_rem <= n_diff[47:0];
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                r_cnt <= r_cnt + DivCntW'(1);
                if (r_cnt == DivCntW'(47)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sq = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (sq > 50'sh0_7FFF_FFFF) begin
            o_quot = 32'h7FFF_FFFF;
        end else if (sq < -50'sh0_8000_0000) begin
            o_quot = 32'h8000_0000;
        end else begin
            o_quot = sq[31:0];
        end
    end

    assign o_done = r_done && !i_ctl.busy;
endmodule

// ===== src/angle_bias_kalman_filter.sv =====
// Top level of the two-state angle and gyro-bias Kalman filter.
// Input channel: i_valid/o_stall with measured angle, gyro rate and time step.
// Output channel: o_valid/i_stall with the filtered angle, one word per input word.
// Configuration: i_cfg_valid/o_cfg_ready with register index and 31-bit data;
// indexes 0..2 are angle noise, bias noise and measurement noise.
// Each word is worked through a sequencer around one shared 32x32 multiplier
// and one restoring divider that yields one quotient bit per cycle.
// The two gain divisions run one after the other, between the prediction
// steps and the update steps.
// The block takes one word at a time; o_stall is high while a word is in work,
// so a new word is taken only once the last one has left the sequencer.
// A result that still waits in the output register holds the sequencer in its
// last step until the register is free.
// The result stays in the output register while i_stall is high.
// Reset clears the estimates and covariance to zero and loads default noise.
module angle_bias_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_measured_angle,
    input  logic [31:0] i_measured_rate,
    input  logic [15:0] i_time_step,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_filtered_angle,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import abkf_pkg::*;

    t_state r_state, n_state;
    logic [CfgW-1:0] r_qa, r_qb, r_rm;
    logic [31:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic [31:0] r_meas, r_rate, r_t, r_y, r_s, r_k0, r_k1, r_p00, r_p01;
    logic [15:0] r_dt;
    logic [31:0] r_out;
    logic        r_ov;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic [31:0]        mres;
    logic [31:0]        add_a, add_b;
    logic               add_sub;
    logic [31:0]        ares;
    logic signed [33:0] ysum, ywrap;
    t_div_ctl           dctl;
    logic               ddone;
    logic [31:0]        dquo;
    logic [31:0]        dnum;
    logic               accept;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_valid = r_ov;
    assign o_filtered_angle = r_out;

    assign prod = mul_a * mul_b;
    assign mres = rnd_sat(prod);
    assign ares = sat34(add_sub ? ($signed({{2{add_a[31]}}, add_a}) - $signed({{2{add_b[31]}}, add_b}))
                                : ($signed({{2{add_a[31]}}, add_a}) + $signed({{2{add_b[31]}}, add_b})));

    assign ysum = $signed({{2{r_meas[31]}}, r_meas}) - $signed({{2{r_ang[31]}}, r_ang});
    always_comb begin
        if (ysum > HalfTurn) begin
            ywrap = ysum - FullTurn;
        end else if (ysum < -HalfTurn) begin
            ywrap = ysum + FullTurn;
        end else begin
            ywrap = ysum;
        end
    end

    assign dnum = (r_state == ST_S) ? r_paa : r_pba;

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dctl),
        .i_num   (dnum),
        .i_den   (r_s),
        .o_done  (ddone),
        .o_quot  (dquo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: pick operands for the shared multiplier and adder, start the divider and pick the next state.
    always_comb begin
        n_state = r_state;
        mul_a = '0;
        mul_b = '0;
        add_a = '0;
        add_b = '0;
        add_sub = 1'b0;
        dctl = '{start: 1'b0, busy: 1'b0};
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_RATE;
            ST_RATE: begin
                add_a = r_rate; add_b = r_bias; add_sub = 1'b1; n_state = ST_ANG;
            end
            ST_ANG: begin
                mul_a = {16'd0, r_dt}; mul_b = r_rate;
                add_a = r_ang; add_b = mres; n_state = ST_T0;
            end
            ST_T0: begin
                mul_a = {16'd0, r_dt}; mul_b = r_pbb;
                add_a = mres; add_b = r_pab; add_sub = 1'b1; n_state = ST_T1;
            end
            ST_T1: begin
                add_a = r_t; add_b = r_pba; add_sub = 1'b1; n_state = ST_T2;
            end
            ST_T2: begin
                add_a = r_t; add_b = {1'b0, r_qa}; n_state = ST_T3;
            end
            ST_T3: begin
                mul_a = {16'd0, r_dt}; mul_b = r_t;
                add_a = r_paa; add_b = mres; n_state = ST_AA;
            end
            ST_AA: begin
                mul_a = {16'd0, r_dt}; mul_b = r_pbb;
                add_a = r_pab; add_b = mres; add_sub = 1'b1; n_state = ST_AB;
            end
            ST_AB: begin
                mul_a = {16'd0, r_dt}; mul_b = r_pbb;
                add_a = r_pba; add_b = mres; add_sub = 1'b1; n_state = ST_BB;
            end
            ST_BB: begin
                mul_a = {1'b0, r_qb}; mul_b = {16'd0, r_dt};
                add_a = r_pbb; add_b = mres; n_state = ST_INNOV;
            end
            ST_INNOV: begin
                add_a = r_paa; add_b = {1'b0, r_rm}; n_state = ST_S;
            end
            ST_S: begin
                dctl.start = 1'b1; n_state = ST_DIV0;
            end
            ST_DIV0: if (ddone) begin
                dctl.start = 1'b1; n_state = ST_DIV1;
            end
            ST_DIV1: if (ddone) n_state = ST_CA;
            ST_CA: begin
                mul_a = r_k0; mul_b = r_y;
                add_a = r_ang; add_b = mres; n_state = ST_CB;
            end
            ST_CB: begin
                mul_a = r_k1; mul_b = r_y;
                add_a = r_bias; add_b = mres; n_state = ST_P00;
            end
            ST_P00: begin
                mul_a = r_k0; mul_b = r_p00;
                add_a = r_paa; add_b = mres; add_sub = 1'b1; n_state = ST_P01;
            end
            ST_P01: begin
                mul_a = r_k0; mul_b = r_p01;
                add_a = r_pab; add_b = mres; add_sub = 1'b1; n_state = ST_P10;
            end
            ST_P10: begin
                mul_a = r_k1; mul_b = r_p00;
                add_a = r_pba; add_b = mres; add_sub = 1'b1; n_state = ST_P11;
            end
            ST_P11: begin
                mul_a = r_k1; mul_b = r_p01;
                add_a = r_pbb; add_b = mres; add_sub = 1'b1; n_state = ST_OUT;
            end
            ST_OUT: if (!r_ov || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= AngleNoiseRst;
            r_qb <= BiasNoiseRst;
            r_rm <= MeasNoiseRst;
            r_ang <= '0; r_bias <= '0;
            r_paa <= '0; r_pab <= '0; r_pba <= '0; r_pbb <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    RegAngleNoise: r_qa <= i_cfg_data;
                    RegBiasNoise:  r_qb <= i_cfg_data;
                    RegMeasNoise:  r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (accept) begin
                    r_meas <= i_measured_angle;
                    r_rate <= i_measured_rate;
                    r_dt   <= i_time_step;
                end
                ST_RATE:  r_rate <= ares;
                ST_ANG:   r_ang <= ares;
                ST_T0:    r_t <= ares;
                ST_T1:    r_t <= ares;
                ST_T2:    r_t <= ares;
                ST_T3:    r_paa <= ares;
                ST_AA:    r_pab <= ares;
                ST_AB:    r_pba <= ares;
                ST_BB: begin
                    r_pbb <= ares;
                    r_y <= sat34(ywrap);
                end
                ST_INNOV: r_s <= ares;
                ST_S: begin
                    r_p00 <= r_paa;
                    r_p01 <= r_pab;
                end
                ST_DIV0:  if (ddone) r_k0 <= dquo;
                ST_DIV1:  if (ddone) r_k1 <= dquo;
                ST_CA:    r_ang <= ares;
                ST_CB:    r_bias <= ares;
                ST_P00:   r_paa <= ares;
                ST_P01:   r_pab <= ares;
                ST_P10:   r_pba <= ares;
                ST_P11:   r_pbb <= ares;
                default: ;
            endcase
            // The finished word enters the output register once that is free.
            if (r_state == ST_OUT && (!r_ov || !i_stall)) begin
                r_out <= r_ang;
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept)
        else $error("word accepted while busy");
    a_result_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_ov || !i_stall)) |=> (r_ov && r_state == ST_IDLE))
        else $error("result not posted");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_out)))
        else $error("stalled result changed");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == ST_IDLE))
        else $error("config ready while busy");
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the angle and gyro-bias Kalman filter.
`timescale 1ns / 1ps

module tb;
    import abkf_pkg::*;

    localparam logic [1:0] RegNone = 2'd3;
    localparam int CycleLimit = 1000000;
    localparam logic signed [31:0] Deg = 32'sd65536;

    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
        logic [15:0] dt;
        bit          typed;
        logic [31:0] typed_angle;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_measured_angle;
    logic [31:0] i_measured_rate;
    logic [15:0] i_time_step;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_filtered_angle;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [30:0] i_cfg_data;

    angle_bias_kalman_filter dut (.*);

    // Filter state and noise settings as the block should hold them.
    logic signed [31:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    logic signed [31:0] q_angle, q_bias, r_meas;

    logic [31:0] angle_expect_q[$];
    int          fail_count;
    int          cycle_count;
    int          stall_mode;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a, b);
        logic signed [63:0] wa, wb;
        wa = a;
        wb = b;
        return clamp32(wa + wb);
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a, b);
        logic signed [63:0] wa, wb;
        wa = a;
        wb = b;
        return clamp32(wa - wb);
    endfunction

    // Round half up: add half an LSB, then floor by an arithmetic shift.
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a, b);
        logic signed [63:0] wa, wb, n;
        wa = a;
        wb = b;
        n = wa * wb + 64'sd32768;
        return clamp32(n >>> 16);
    endfunction

    function automatic logic signed [31:0] q_div(input logic signed [31:0] num, den);
        logic signed [63:0] wn, wd;
        if (den == 0) return 0;
        wn = num;
        wd = den;
        return clamp32((wn <<< 16) / wd);
    endfunction

    function automatic logic [31:0] predict_angle(input logic signed [31:0] meas,
                                                  input logic signed [31:0] rate_in,
                                                  input logic [15:0] dt_in);
        logic signed [31:0] dt, rate, t, s, k0, k1, p00, p01, y;
        logic signed [63:0] y64;
        dt = {16'd0, dt_in};
        rate = q_sub(rate_in, est_bias);
        est_angle = q_add(est_angle, q_mul(dt, rate));
        t = q_mul(dt, p_bb);
        t = q_sub(t, p_ab);
        t = q_sub(t, p_ba);
        t = q_add(t, q_angle);
        p_aa = q_add(p_aa, q_mul(dt, t));
        p_ab = q_sub(p_ab, q_mul(dt, p_bb));
        p_ba = q_sub(p_ba, q_mul(dt, p_bb));
        p_bb = q_add(p_bb, q_mul(q_bias, dt));
        // The innovation is wrapped into one turn only once.
        y64 = 64'(meas) - 64'(est_angle);
        if (y64 > 64'sd11796480) y64 = y64 - 64'sd23592960;
        else if (y64 < -64'sd11796480) y64 = y64 + 64'sd23592960;
        y = clamp32(y64);
        s = q_add(p_aa, r_meas);
        k0 = q_div(p_aa, s);
        k1 = q_div(p_ba, s);
        est_angle = q_add(est_angle, q_mul(k0, y));
        est_bias = q_add(est_bias, q_mul(k1, y));
        p00 = p_aa;
        p01 = p_ab;
        p_aa = q_sub(p_aa, q_mul(k0, p00));
        p_ab = q_sub(p_ab, q_mul(k0, p01));
        p_ba = q_sub(p_ba, q_mul(k1, p00));
        p_bb = q_sub(p_bb, q_mul(k1, p01));
        return est_angle;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // Output side: check each accepted word, and stall on a pattern that
    // switches between no stalls, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (angle_expect_q.size() == 0) begin
                $error("filtered_angle: unexpected word %h", o_filtered_angle);
                fail_count <= fail_count + 1;
            end else begin
                if (o_filtered_angle !== angle_expect_q[0]) begin
                    $error("filtered_angle: expected %h, actual %h",
                           angle_expect_q[0], o_filtered_angle);
                    fail_count <= fail_count + 1;
                end
                void'(angle_expect_q.pop_front());
            end
        end
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            RegAngleNoise: q_angle = {1'b0, data};
            RegBiasNoise:  q_bias = {1'b0, data};
            RegMeasNoise:  r_meas = {1'b0, data};
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (angle_expect_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    int burst_left;

    // Keeps valid high inside a burst; lowers it only for a gap.
    task automatic send_word(input t_row r);
        logic [31:0] predicted;
        i_valid <= 1'b1;
        i_measured_angle <= r.angle;
        i_measured_rate <= r.rate;
        i_time_step <= r.dt;
        do @(posedge i_clk); while (o_stall);
        predicted = predict_angle(r.angle, r.rate, r.dt);
        angle_expect_q.push_back(r.typed ? r.typed_angle : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 1)) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_row random_row();
        t_row r;
        r.typed = 0;
        r.typed_angle = 0;
        if ($urandom_range(0, 9) < 8) begin
            // Plausible sensor data keeps the filter in its working range.
            r.angle = $urandom_range(0, 800 * 65536) - 400 * 65536;
            r.rate = $urandom_range(0, 1000 * 65536) - 500 * 65536;
            r.dt = 16'($urandom_range(1, 3000));
        end else begin
            r.angle = $urandom();
            r.rate = $urandom();
            r.dt = 16'($urandom());
        end
        return r;
    endfunction

    t_row directed[$];

    initial begin
        t_row r;
        logic [30:0] cfg_a, cfg_b, cfg_c;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_measured_angle <= '0;
        i_measured_rate <= '0;
        i_time_step <= '0;
        i_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= RegAngleNoise;
        i_cfg_data <= '0;
        fail_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        burst_left = 0;
        est_angle = 0; est_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        q_angle = {1'b0, AngleNoiseRst};
        q_bias = {1'b0, BiasNoiseRst};
        r_meas = {1'b0, MeasNoiseRst};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A zero time step right after reset leaves the estimate at zero.
        directed = '{
            '{100 * Deg, 0, 16'd0, 1, 32'd0},
            '{200 * Deg, 10 * Deg, 16'd655, 0, 0},
            '{-200 * Deg, -10 * Deg, 16'd655, 0, 0},
            '{180 * Deg, 0, 16'hFFFF, 0, 0},
            '{-180 * Deg, 0, 16'hFFFF, 0, 0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0},
            '{32'h8000_0000, 32'h8000_0000, 16'hFFFF, 0, 0},
            '{0, 32'h7FFF_FFFF, 16'hFFFF, 0, 0},
            '{32'h8000_0000, 0, 16'd1, 0, 0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 0, 0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 0, 0},
            '{0, 0, 16'd0, 0, 0},
            '{45 * Deg, 3 * Deg, 16'd1000, 0, 0},
            '{-90 * Deg, -3 * Deg, 16'd1000, 0, 0}
        };
        foreach (directed[i]) send_word(directed[i]);

        for (int ph = 0; ph < 8; ph++) begin
            i_valid <= 1'b0;
            wait_idle();
            case (ph)
                0: begin cfg_a = '0; cfg_b = '0; cfg_c = '0; end
                1: begin cfg_a = '1; cfg_b = '1; cfg_c = '1; end
                7: begin
                    cfg_a = AngleNoiseRst; cfg_b = BiasNoiseRst; cfg_c = MeasNoiseRst;
                end
                default: begin
                    if (ph % 2 == 0) begin
                        cfg_a = 31'($urandom());
                        cfg_b = 31'($urandom());
                        cfg_c = 31'($urandom());
                    end else begin
                        cfg_a = 31'($urandom_range(0, 2 * 65536));
                        cfg_b = 31'($urandom_range(0, 65536));
                        cfg_c = 31'($urandom_range(0, 4 * 65536));
                    end
                end
            endcase
            write_reg(RegAngleNoise, cfg_a);
            write_reg(RegBiasNoise, cfg_b);
            write_reg(RegMeasNoise, cfg_c);
            // An index past the last register must change nothing.
            if (ph == 1) write_reg(RegNone, 31'h1234_5678);
            // With all noise zero, the first word drives the angle variance to
            // zero, and a zero time step on the next word then makes S zero.
            if (ph == 0) begin
                r = random_row();
                send_word(r);
                r = random_row();
                r.dt = '0;
                send_word(r);
            end
            repeat (ph == 0 ? 20 : (ph == 1 ? 30 : 195)) begin
                r = random_row();
                send_word(r);
            end
        end

        i_valid <= 1'b0;
        while (angle_expect_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
